FILE: sv/irms_pkg.sv
package irms_pkg;

	localparam int SUM_BITS     = 58;
	localparam int REG_BITS     = 13;
	localparam int DEN_BITS     = 26;
	localparam int QUO_BITS     = 50;
	localparam int OUT_BITS     = 24;
	localparam int CFG_IDX_BITS = 2;

	typedef logic [SUM_BITS-1:0]     sum_t;
	typedef logic [REG_BITS-1:0]     dim_t;
	typedef logic [DEN_BITS-1:0]     den_t;
	typedef logic [QUO_BITS-1:0]     quo_t;
	typedef logic [OUT_BITS-1:0]     out_t;
	typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

	localparam sum_t SUM_MAX = '1;
	localparam quo_t QUO_CAP = quo_t'(1) << 48;
	localparam out_t OUT_MAX = '1;

	localparam cfg_idx_t CFG_WIDTH  = cfg_idx_t'(0);
	localparam cfg_idx_t CFG_HEIGHT = cfg_idx_t'(1);

endpackage

FILE: sv/irms_mul.sv
module irms_mul #(
	parameter int WIDTH = 16
) (
	input  logic                 clk,
	input  logic [WIDTH-1:0]     op_a,
	input  logic [WIDTH-1:0]     op_b,
	output logic [2*WIDTH-1:0]   prod
);

	logic [2*WIDTH-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end

	assign prod = prod_q;

endmodule

FILE: sv/irms_div.sv
module irms_div #(
	parameter int FRACTION_BITS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  irms_pkg::sum_t      num,
	input  irms_pkg::den_t      den,
	output logic                done,
	output irms_pkg::quo_t      quo
);

	localparam int NUM_BITS = irms_pkg::SUM_BITS + 2 * FRACTION_BITS;
	localparam int CNT_BITS = $clog2(NUM_BITS + 1);
	localparam int DB       = irms_pkg::DEN_BITS;

	logic [NUM_BITS-1:0] num_q;
	irms_pkg::den_t      den_q;
	irms_pkg::den_t      rem_q;
	irms_pkg::quo_t      quo_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                run_q;
	logic                done_q;

	logic [DB:0]         rem_sh;
	logic                ge;
	irms_pkg::quo_t      quo_sh;

	always_comb begin
		rem_sh = {rem_q, num_q[NUM_BITS-1]};
		ge     = rem_sh >= {1'b0, den_q};
		quo_sh = {quo_q[irms_pkg::QUO_BITS-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_BITS'(NUM_BITS);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= NUM_BITS'(num) << (2 * FRACTION_BITS);
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (run_q) begin
			num_q <= num_q << 1;
			rem_q <= ge ? DB'(rem_sh - {1'b0, den_q}) : rem_sh[DB-1:0];
			// clamp keeps the quotient bounded once it passes the cap
			quo_q <= (quo_sh > irms_pkg::QUO_CAP) ? irms_pkg::QUO_CAP : quo_sh;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

FILE: sv/irms_sqrt.sv
module irms_sqrt (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  irms_pkg::quo_t  value,
	output logic            done,
	output irms_pkg::quo_t  root
);

	localparam int QB = irms_pkg::QUO_BITS;

	irms_pkg::quo_t rad_q;
	irms_pkg::quo_t res_q;
	irms_pkg::quo_t bit_q;
	logic           run_q;
	logic           done_q;

	irms_pkg::quo_t trial;
	logic           fits;

	always_comb begin
		trial = res_q + bit_q;
		fits  = rad_q >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
			end else if (run_q && bit_q == QB'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= value;
			res_q <= '0;
			// highest even power that the capped quotient can reach
			bit_q <= QB'(1) << 48;
		end else if (run_q) begin
			if (fits) begin
				rad_q <= rad_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q;

endmodule

FILE: sv/image_rms_difference_core.sv
// rms difference of two rgb images, one pixel pair per word on the input side
// input: a word is taken on a clock edge with start high and busy low; busy
//   rises on the next cycle and stays high while the word is worked on
// a pixel pair keeps busy high while, for each of red, green, blue in turn,
//   one state forms the difference, one squares it on the shared
//   multiplier and one adds it into the saturating 58-bit sum; a new pair
//   is taken only once busy is low again
// a pair with final_pixel set then forms width*height on the same
//   multiplier and triples it, then runs a bit-serial restoring divide of
//   58+2*FRACTION_BITS steps and a 25-step digit-by-digit root
// output: result_valid is high for one cycle with rms_value in 16.8 fixed
//   point; the receiver cannot stall, the word must be taken in that cycle,
//   and busy is already low then so the next pair can be taken at once
// config: cfg_ready is always high; write image_width at index 0 and
//   image_height at index 1 only while busy is low
// reset: sum cleared, both dimensions set to 1, no word in flight
module image_rms_difference_core #(
	parameter int SAMPLE_BITS   = 16,
	parameter int MAX_DIMENSION = 4096,
	parameter int FRACTION_BITS = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [15:0]               red_a,
	input  logic [15:0]               green_a,
	input  logic [15:0]               blue_a,
	input  logic [15:0]               red_b,
	input  logic [15:0]               green_b,
	input  logic [15:0]               blue_b,
	input  logic                      final_pixel,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  irms_pkg::cfg_idx_t        cfg_index,
	input  irms_pkg::dim_t            cfg_data,
	output logic                      result_valid,
	output irms_pkg::out_t            rms_value
);

	localparam int RB       = irms_pkg::REG_BITS;
	localparam int SB       = irms_pkg::SUM_BITS;
	localparam int MUL_BITS = (SAMPLE_BITS > RB) ? SAMPLE_BITS : RB;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DIFF = 4'd1;
	localparam logic [3:0] ST_MUL  = 4'd2;
	localparam logic [3:0] ST_ADD  = 4'd3;
	localparam logic [3:0] ST_DIM  = 4'd4;
	localparam logic [3:0] ST_DEN  = 4'd5;
	localparam logic [3:0] ST_DIV  = 4'd6;
	localparam logic [3:0] ST_SQRT = 4'd7;

	localparam logic [1:0] CH_LAST = 2'd2;

	logic [3:0]             state_q;
	logic [1:0]             ch_q;
	logic                   final_q;
	irms_pkg::sum_t         sum_q;
	irms_pkg::dim_t         width_q;
	irms_pkg::dim_t         height_q;
	logic [SAMPLE_BITS-1:0] samp_a_q [3];
	logic [SAMPLE_BITS-1:0] samp_b_q [3];
	logic [SAMPLE_BITS-1:0] diff_q;
	logic                   result_valid_q;
	irms_pkg::out_t         rms_q;

	logic [MUL_BITS-1:0]    op_a;
	logic [MUL_BITS-1:0]    op_b;
	logic [2*MUL_BITS-1:0]  prod;
	irms_pkg::dim_t         width_c;
	irms_pkg::dim_t         height_c;
	logic [SB:0]            sum_add;
	irms_pkg::den_t         den_c;
	logic [SAMPLE_BITS-1:0] cur_a;
	logic [SAMPLE_BITS-1:0] cur_b;
	logic                   div_start;
	logic                   div_done;
	logic                   sqrt_start;
	logic                   sqrt_done;
	irms_pkg::quo_t         quo;
	irms_pkg::quo_t         root;

	function automatic irms_pkg::dim_t clamp_dim(input irms_pkg::dim_t v);
		if (v == '0)
			return RB'(1);
		else if (v > RB'(MAX_DIMENSION))
			return RB'(MAX_DIMENSION);
		else
			return v;
	endfunction

	always_comb begin
		width_c  = clamp_dim(width_q);
		height_c = clamp_dim(height_q);
		cur_a    = samp_a_q[ch_q];
		cur_b    = samp_b_q[ch_q];
		if (state_q == ST_DIM) begin
			op_a = MUL_BITS'(width_c);
			op_b = MUL_BITS'(height_c);
		end else begin
			op_a = MUL_BITS'(diff_q);
			op_b = MUL_BITS'(diff_q);
		end
		sum_add    = {1'b0, sum_q} + (SB + 1)'(prod);
		den_c      = irms_pkg::DEN_BITS'(prod) + (irms_pkg::DEN_BITS'(prod) << 1);
		div_start  = state_q == ST_DEN;
		sqrt_start = (state_q == ST_DIV) && div_done;
	end

	irms_mul #(
		.WIDTH(MUL_BITS)
	) u_mul (
		.clk  (clk),
		.op_a (op_a),
		.op_b (op_b),
		.prod (prod)
	);

	irms_div #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (sum_q),
		.den    (den_c),
		.done   (div_done),
		.quo    (quo)
	);

	irms_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.value  (quo),
		.done   (sqrt_done),
		.root   (root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			ch_q           <= '0;
			final_q        <= 1'b0;
			sum_q          <= '0;
			width_q        <= RB'(1);
			height_q       <= RB'(1);
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			if (cfg_valid) begin
				if (cfg_index == irms_pkg::CFG_WIDTH)
					width_q <= cfg_data;
				else if (cfg_index == irms_pkg::CFG_HEIGHT)
					height_q <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						final_q <= final_pixel;
						ch_q    <= '0;
						state_q <= ST_DIFF;
					end
				end
				ST_DIFF: state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_ADD;
				ST_ADD: begin
					sum_q <= sum_add[SB] ? irms_pkg::SUM_MAX : sum_add[SB-1:0];
					if (ch_q == CH_LAST)
						state_q <= final_q ? ST_DIM : ST_IDLE;
					else begin
						ch_q    <= ch_q + 1'b1;
						state_q <= ST_DIFF;
					end
				end
				ST_DIM: state_q <= ST_DEN;
				ST_DEN: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done)
						state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (sqrt_done) begin
						result_valid_q <= 1'b1;
						sum_q          <= '0;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			samp_a_q[0] <= red_a[SAMPLE_BITS-1:0];
			samp_a_q[1] <= green_a[SAMPLE_BITS-1:0];
			samp_a_q[2] <= blue_a[SAMPLE_BITS-1:0];
			samp_b_q[0] <= red_b[SAMPLE_BITS-1:0];
			samp_b_q[1] <= green_b[SAMPLE_BITS-1:0];
			samp_b_q[2] <= blue_b[SAMPLE_BITS-1:0];
		end
		if (state_q == ST_DIFF)
			diff_q <= (cur_a >= cur_b) ? cur_a - cur_b : cur_b - cur_a;
		if (state_q == ST_SQRT && sqrt_done)
			rms_q <= (root > irms_pkg::quo_t'(irms_pkg::OUT_MAX)) ?
				irms_pkg::OUT_MAX : root[irms_pkg::OUT_BITS-1:0];
	end

	assign busy         = state_q != ST_IDLE;
	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign rms_value    = rms_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy did not rise after an accepted word");

	a_result_from_root: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(state_q == ST_SQRT && sqrt_done))
		else $error("result strobe without a finished root");

	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (!busy && sum_q == '0 && !$past(result_valid)))
		else $error("result shown while busy or sum not cleared");

	a_div_start_once: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> (state_q == ST_DIV && !div_start))
		else $error("divider started out of sequence");

endmodule
